// File: hdl/aph_pkg.sv
// Playhead timer package: widths, command and register codes, FSM states,
// shared-unit request/result types and the time mask helper.
// No dependencies.
`timescale 1ns / 1ps

package aph_pkg;

  localparam int TIME_BITS  = 32;   // significant bits of a time value
  localparam int DATA_W     = 32;   // Q16.16 time fields
  localparam int SPEED_W    = 16;   // Q8.8 speed
  localparam int CMD_W      = 3;
  localparam int FRAC_SHIFT = 8;    // drop fraction bits of speed
  localparam int ALU_W      = DATA_W + SPEED_W + 2;
  localparam int STEP_W     = DATA_W + SPEED_W - FRAC_SHIFT;
  localparam int MUL_STEPS  = SPEED_W;
  localparam int DIV_STEPS  = DATA_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int MUL_IDX_W  = $clog2(MUL_STEPS);
  localparam int ADDR_W     = 4;
  localparam int PDATA_W    = 32;

  localparam logic [DATA_W-1:0]  DURATION_RST = DATA_W'(65536);
  localparam logic [SPEED_W-1:0] SPEED_RST    = SPEED_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_PLAY     = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_REWIND   = 3'd4,
    CMD_RESUME   = 3'd5,
    CMD_SEEK     = 3'd6,
    CMD_SET_TIME = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_SPEED    = 2'd1,
    REG_LOOPING  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_MOVE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0]  duration;
    logic [SPEED_W-1:0] speed;
    logic               looping;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             neg;
    logic             zero;
  } alu_res_t;

  // keep only the TIME_BITS low bits of a time value
  function automatic logic [DATA_W-1:0] tmask(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] m;
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = (i < TIME_BITS) ? x[i] : 1'b0;
    end
    return m;
  endfunction

endpackage

// File: hdl/aph_if.sv
// Valid/ready channel interfaces for timer requests and results.
// Depends on aph_pkg.
`timescale 1ns / 1ps

interface aph_in_if;
  import aph_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] amount;
  logic              seek_paused;
  logic              seek_rewinding;

  modport source (output valid, command, amount, seek_paused, seek_rewinding,
                  input ready);
  modport sink (input valid, command, amount, seek_paused, seek_rewinding,
                output ready);
endinterface

interface aph_out_if;
  import aph_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] position;
  logic              is_paused;
  logic              is_stopped;
  logic              is_rewinding;
  logic              ended;

  modport source (output valid, position, is_paused, is_stopped, is_rewinding, ended,
                  input ready);
  modport sink (input valid, position, is_paused, is_stopped, is_rewinding, ended,
                output ready);
endinterface

// File: hdl/aph_alu.sv
// Shared add/subtract unit of the playhead timer, with sign and zero flags.
// Depends on aph_pkg.
`timescale 1ns / 1ps

module aph_alu (
  input  aph_pkg::alu_req_t req,
  output aph_pkg::alu_res_t res
);
  import aph_pkg::*;

  logic [ALU_W-1:0] sum;

  assign sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign res.sum  = sum;
  assign res.neg  = sum[ALU_W-1];
  assign res.zero = (sum == '0);

endmodule

// File: hdl/aph_cfg.sv
// APB-style register file of the playhead timer: duration, speed, looping.
// Depends on aph_pkg.
`timescale 1ns / 1ps

module aph_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aph_pkg::ADDR_W-1:0] paddr,
  input  logic [aph_pkg::PDATA_W-1:0] pwdata,
  output logic [aph_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,
  output aph_pkg::cfg_t              cfg
);
  import aph_pkg::*;

  logic [DATA_W-1:0]  duration_r;
  logic [SPEED_W-1:0] speed_r;
  logic               looping_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= tmask(DURATION_RST);
      speed_r    <= SPEED_RST;
      looping_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DURATION: duration_r <= tmask(pwdata[DATA_W-1:0]);
        REG_SPEED:    speed_r    <= pwdata[SPEED_W-1:0];
        REG_LOOPING:  looping_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DURATION: prdata = PDATA_W'(duration_r);
      REG_SPEED:    prdata = PDATA_W'(speed_r);
      REG_LOOPING:  prdata = PDATA_W'(looping_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.duration = duration_r;
  assign cfg.speed    = speed_r;
  assign cfg.looping  = looping_r;

endmodule

// File: hdl/aph_core.sv
// Playhead timer sequencer: playhead state, shift-add multiply, bit-serial
// remainder and tick moves, all through one shared aph_alu. Output register.
// Depends on aph_pkg, aph_if, aph_alu.
`timescale 1ns / 1ps

module aph_core (
  input  logic          clk,
  input  logic          rst_n,
  input  aph_pkg::cfg_t cfg,
  aph_in_if.sink        in_ch,
  aph_out_if.source     out_ch
);
  import aph_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ALU_W-1:0]   work_r, work_nxt;
  logic [DATA_W-1:0]  step_r, step_nxt;
  logic [DATA_W-1:0]  amt_r, amt_nxt;
  logic [DATA_W-1:0]  pos_r, pos_nxt;
  logic               paused_r, paused_nxt;
  logic               stopped_r, stopped_nxt;
  logic               rew_r, rew_nxt;
  logic               ended_r, ended_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_pos_r, out_pos_nxt;
  logic               out_paused_r, out_paused_nxt;
  logic               out_stopped_r, out_stopped_nxt;
  logic               out_rew_r, out_rew_nxt;
  logic               out_ended_r, out_ended_nxt;

  alu_req_t           alu_req;
  alu_res_t           alu_res;
  logic [ALU_W-1:0]   dur_x;
  logic [ALU_W-1:0]   div_shift;
  logic               work_le0;
  logic               res_pos;
  logic               halt;

  aph_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign dur_x     = ALU_W'(cfg.duration);
  assign div_shift = {work_r[ALU_W-2:0], amt_r[DATA_W-1]};
  assign work_le0  = work_r[ALU_W-1] || (work_r == '0);
  assign res_pos   = !alu_res.neg && !alu_res.zero;

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      paused_r    <= 1'b0;
      stopped_r   <= 1'b1;
      rew_r       <= 1'b0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      paused_r    <= paused_nxt;
      stopped_r   <= stopped_nxt;
      rew_r       <= rew_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    work_r        <= work_nxt;
    step_r        <= step_nxt;
    amt_r         <= amt_nxt;
    out_pos_r     <= out_pos_nxt;
    out_paused_r  <= out_paused_nxt;
    out_stopped_r <= out_stopped_nxt;
    out_rew_r     <= out_rew_nxt;
    out_ended_r   <= out_ended_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    work_nxt        = work_r;
    step_nxt        = step_r;
    amt_nxt         = amt_r;
    pos_nxt         = pos_r;
    paused_nxt      = paused_r;
    stopped_nxt     = stopped_r;
    rew_nxt         = rew_r;
    ended_nxt       = ended_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_pos_nxt     = out_pos_r;
    out_paused_nxt  = out_paused_r;
    out_stopped_nxt = out_stopped_r;
    out_rew_nxt     = out_rew_r;
    out_ended_nxt   = out_ended_r;
    alu_req.a       = work_r;
    alu_req.b       = dur_x;
    alu_req.sub     = 1'b1;
    halt            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          amt_nxt   = in_ch.amount;
          ended_nxt = 1'b0;
          state_nxt = S_DONE;
          unique case (cmd_t'(in_ch.command))
            CMD_TICK: begin
              if (!stopped_r && !paused_r) begin
                work_nxt  = '0;
                cnt_nxt   = CNT_W'(MUL_STEPS - 1);
                state_nxt = S_MUL;
              end
            end
            CMD_PLAY: begin
              paused_nxt  = 1'b0;
              stopped_nxt = 1'b0;
              rew_nxt     = 1'b0;
            end
            CMD_PAUSE:  paused_nxt = 1'b1;
            CMD_STOP: begin
              stopped_nxt = 1'b1;
              paused_nxt  = 1'b0;
              pos_nxt     = rew_r ? cfg.duration : '0;
            end
            CMD_REWIND: begin
              paused_nxt  = 1'b0;
              stopped_nxt = 1'b0;
              rew_nxt     = 1'b1;
            end
            CMD_RESUME: paused_nxt = 1'b0;
            CMD_SEEK: begin
              paused_nxt = in_ch.seek_paused;
              rew_nxt    = in_ch.seek_rewinding;
              if (cfg.duration == '0) begin
                pos_nxt = '0;
              end else begin
                work_nxt  = '0;
                cnt_nxt   = CNT_W'(DIV_STEPS - 1);
                state_nxt = S_DIV;
              end
            end
            CMD_SET_TIME: pos_nxt = tmask(in_ch.amount);
          endcase
        end
      end

      // MSB-first shift-add of amount * speed
      S_MUL: begin
        alu_req.a   = {work_r[ALU_W-2:0], 1'b0};
        alu_req.b   = cfg.speed[cnt_r[MUL_IDX_W-1:0]] ? ALU_W'(amt_r) : '0;
        alu_req.sub = 1'b0;
        work_nxt    = alu_res.sum;
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_CLAMP;
      end

      // step = min(product >> 8, duration)
      S_CLAMP: begin
        alu_req.a   = dur_x;
        alu_req.b   = ALU_W'(work_r[FRAC_SHIFT +: STEP_W]);
        alu_req.sub = 1'b1;
        step_nxt    = alu_res.neg ? cfg.duration : work_r[FRAC_SHIFT +: DATA_W];
        state_nxt   = S_MOVE;
      end

      S_MOVE: begin
        alu_req.a   = ALU_W'(pos_r);
        alu_req.b   = ALU_W'(step_r);
        alu_req.sub = rew_r;
        work_nxt    = alu_res.sum;
        state_nxt   = S_CHECK;
      end

      // compare or wrap the moved position against duration
      S_CHECK: begin
        alu_req.a   = work_r;
        alu_req.b   = dur_x;
        alu_req.sub = !(rew_r && cfg.looping && work_le0);
        state_nxt   = S_DONE;
        if (!rew_r) begin
          if (cfg.looping) begin
            pos_nxt = alu_res.neg ? work_r[DATA_W-1:0] : alu_res.sum[DATA_W-1:0];
          end else if (res_pos) begin
            halt = 1'b1;
          end else begin
            pos_nxt = work_r[DATA_W-1:0];
          end
        end else if (cfg.looping) begin
          if (work_le0 || res_pos) pos_nxt = alu_res.sum[DATA_W-1:0];
          else                     pos_nxt = work_r[DATA_W-1:0];
        end else if (work_r[ALU_W-1] || res_pos) begin
          halt = 1'b1;
        end else begin
          pos_nxt = work_r[DATA_W-1:0];
        end
        if (halt) begin
          stopped_nxt = 1'b1;
          paused_nxt  = 1'b0;
          pos_nxt     = rew_r ? cfg.duration : '0;
          ended_nxt   = 1'b1;
        end
      end

      // restoring remainder, one dividend bit per cycle
      S_DIV: begin
        alu_req.a   = div_shift;
        alu_req.b   = dur_x;
        alu_req.sub = 1'b1;
        work_nxt    = alu_res.neg ? div_shift : alu_res.sum;
        amt_nxt     = {amt_r[DATA_W-2:0], 1'b0};
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          pos_nxt   = work_nxt[DATA_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_pos_nxt     = pos_r;
          out_paused_nxt  = paused_r;
          out_stopped_nxt = stopped_r;
          out_rew_nxt     = rew_r;
          out_ended_nxt   = ended_r;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.is_paused    = out_paused_r;
  assign out_ch.is_stopped   = out_stopped_r;
  assign out_ch.is_rewinding = out_rew_r;
  assign out_ch.ended        = out_ended_r;

endmodule

// File: hdl/animation_playhead_timer.sv
// Animation playhead timer: a Q16.16 playhead driven by tick, transport,
// seek and set-time requests, with one result per request. A tick on a
// running timer runs 16 shift-add multiply steps, then clamp, move, end
// check and the load of the output register; a seek runs 32 restoring
// remainder steps and the output load, or only the output load when the
// duration is zero, as does every other request and a tick ignored by a
// paused or stopped timer. Multiply, clamp, move and remainder arithmetic
// goes through a single shared 50-bit add/subtract unit, and in_ch.ready
// is high only while no request is being worked on, so the next request
// is accepted no earlier than the edge at which the result can be taken.
// A finished result sits in the output register until taken; while it
// waits, the next finished request holds in its last step and the input
// stays stalled. Registers (APB, byte address 4*i): duration at 0x0,
// speed (Q8.8) at 0x4, looping at 0x8; write them only while idle.
// Depends on aph_pkg, aph_if, aph_cfg, aph_core.
`timescale 1ns / 1ps

module animation_playhead_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  aph_in_if.sink                       in_ch,
  aph_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aph_pkg::ADDR_W-1:0]   paddr,
  input  logic [aph_pkg::PDATA_W-1:0]  pwdata,
  output logic [aph_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import aph_pkg::*;

  cfg_t cfg;

  aph_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aph_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: hdl/aph_chk.sv
// Port-level checks for the playhead timer, bound to the top level.
// Depends on aph_pkg and animation_playhead_timer.
`timescale 1ns / 1ps

module aph_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [aph_pkg::DATA_W-1:0]  out_position,
  input logic                        out_is_paused,
  input logic                        out_is_stopped,
  input logic                        out_is_rewinding,
  input logic                        out_ended,
  input logic                        pready
);
  import aph_pkg::*;

  // one request in flight at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before being taken");

  // running off an end leaves a stopped, unpaused timer
  a_ended_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ended |-> out_is_stopped && !out_is_paused)
    else $error("ended result without stop");

  a_ended_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ended && !out_is_rewinding |-> out_position == '0)
    else $error("forward end not parked at zero");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("config port stalled");

endmodule

bind animation_playhead_timer aph_chk u_aph_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_position     (out_ch.position),
  .out_is_paused    (out_ch.is_paused),
  .out_is_stopped   (out_ch.is_stopped),
  .out_is_rewinding (out_ch.is_rewinding),
  .out_ended        (out_ch.ended),
  .pready           (pready)
);

// File: tb/sv/playhead_checker.sv
// Playhead timer checker: tracks register writes, predicts the status for
// every accepted request and compares it with each accepted result.
// Depends on aph_pkg and aph_if.
`timescale 1ns / 1ps

module playhead_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  aph_in_if                           in_ch,
  aph_out_if                          out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [aph_pkg::ADDR_W-1:0]  paddr,
  input  logic [aph_pkg::PDATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);
  import aph_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] position;
    logic              paused;
    logic              stopped;
    logic              rewinding;
    logic              ended;
  } playhead_t;

  localparam logic [63:0] TIME_KEEP = (64'd1 << TIME_BITS) - 64'd1;

  logic [63:0]        dur_r;
  logic [SPEED_W-1:0] speed_r;
  logic               loop_r;
  logic [63:0]        pos_r;
  logic               paused_r;
  logic               stopped_r;
  logic               rewind_r;

  playhead_t expected_status_q[$];
  playhead_t head;
  playhead_t predicted;

  // running past an end: park at the end we came from
  function automatic void park_playhead();
    stopped_r = 1'b1;
    paused_r  = 1'b0;
    pos_r     = rewind_r ? dur_r : 64'd0;
  endfunction

  function automatic logic apply_tick(input logic [DATA_W-1:0] amt);
    logic [63:0] step;
    logic [63:0] p;
    step = (64'(amt) * 64'(speed_r)) >> FRAC_SHIFT;
    if (step > dur_r) step = dur_r;
    p = pos_r;
    if (stopped_r || paused_r) return 1'b0;
    if (!rewind_r) begin
      p = p + step;
      if (loop_r) begin
        if (p >= dur_r) p = p - dur_r;
      end else if (p > dur_r) begin
        park_playhead();
        return 1'b1;
      end
      pos_r = p & TIME_KEEP;
      return 1'b0;
    end
    if (loop_r) begin
      if (p <= step) begin
        p = dur_r - (step - p);
      end else begin
        p = p - step;
        if (p > dur_r) p = p - dur_r;
      end
      pos_r = p & TIME_KEEP;
      return 1'b0;
    end
    if (step > p || p - step > dur_r) begin
      park_playhead();
      return 1'b1;
    end
    pos_r = p - step;
    return 1'b0;
  endfunction

  function automatic playhead_t advance_playhead(input cmd_t cmd,
                                                 input logic [DATA_W-1:0] amt,
                                                 input logic sp, input logic sr);
    playhead_t r;
    logic      hit;
    hit = 1'b0;
    case (cmd)
      CMD_TICK:   hit = apply_tick(amt);
      CMD_PLAY: begin
        paused_r  = 1'b0;
        stopped_r = 1'b0;
        rewind_r  = 1'b0;
      end
      CMD_PAUSE:  paused_r = 1'b1;
      CMD_STOP:   park_playhead();
      CMD_REWIND: begin
        paused_r  = 1'b0;
        stopped_r = 1'b0;
        rewind_r  = 1'b1;
      end
      CMD_RESUME: paused_r = 1'b0;
      CMD_SEEK: begin
        pos_r    = (dur_r != 0) ? (64'(amt) % dur_r) : 64'd0;
        paused_r = sp;
        rewind_r = sr;
      end
      default:    pos_r = 64'(amt) & TIME_KEEP;
    endcase
    r.position  = pos_r[DATA_W-1:0];
    r.paused    = paused_r;
    r.stopped   = stopped_r;
    r.rewinding = rewind_r;
    r.ended     = hit;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dur_r     = 64'(DURATION_RST);
      speed_r   = SPEED_RST;
      loop_r    = 1'b0;
      pos_r     = 64'd0;
      paused_r  = 1'b0;
      stopped_r = 1'b1;
      rewind_r  = 1'b0;
      expected_status_q.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_DURATION: dur_r = 64'(pwdata) & 64'hFFFF_FFFF & TIME_KEEP;
          REG_SPEED:    speed_r = pwdata[SPEED_W-1:0];
          REG_LOOPING:  loop_r = pwdata[0];
          default: ;
        endcase
      end
      // retire first: a result taken on the same edge as a request is older
      if (out_ch.valid && out_ch.ready) begin
        if (expected_status_q.size() == 0) begin
          $error("result with no request waiting: position %h", out_ch.position);
          mismatches++;
        end else begin
          head = expected_status_q.pop_front();
          compare_field("position", head.position, out_ch.position);
          compare_field("is_paused", DATA_W'(head.paused), DATA_W'(out_ch.is_paused));
          compare_field("is_stopped", DATA_W'(head.stopped), DATA_W'(out_ch.is_stopped));
          compare_field("is_rewinding", DATA_W'(head.rewinding),
                        DATA_W'(out_ch.is_rewinding));
          compare_field("ended", DATA_W'(head.ended), DATA_W'(out_ch.ended));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = advance_playhead(cmd_t'(in_ch.command), in_ch.amount,
                                     in_ch.seek_paused, in_ch.seek_rewinding);
        expected_status_q = {expected_status_q, predicted};
      end
      outstanding <= expected_status_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Playhead timer testbench top: clock, reset, register writes, directed and
// random requests with random idling on both channels, and the verdict.
// Depends on aph_pkg, aph_if, animation_playhead_timer and playhead_checker.
`timescale 1ns / 1ps

module tb_top;
  import aph_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int sent_count;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit tx_calm;
  bit rx_calm = 1'b0;

  logic [DATA_W-1:0]  cur_dur;
  logic [SPEED_W-1:0] cur_speed;

  aph_in_if  in_ch();
  aph_out_if out_ch();

  animation_playhead_timer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  playhead_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rx_calm) rx_hold = pick_gap();
    end
    if ($urandom_range(0, 199) == 0) rx_calm = ~rx_calm;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [DATA_W-1:0] amt,
                              input logic sp, input logic sr);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.amount         <= amt;
    in_ch.seek_paused    <= sp;
    in_ch.seek_rewinding <= sr;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // drop valid, then hold off until every result is back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [DATA_W-1:0] dur, input logic [SPEED_W-1:0] spd,
                            input logic lp);
    wait_idle();
    write_reg(REG_DURATION, PDATA_W'(dur));
    write_reg(REG_SPEED, PDATA_W'(spd));
    write_reg(REG_LOOPING, PDATA_W'(lp));
    cur_dur   = dur;
    cur_speed = spd;
  endtask

  // deltas aimed at a fraction of the duration so ends get hit often
  function automatic logic [DATA_W-1:0] tick_amount();
    logic [63:0] target;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom();
    if (r < 5 || cur_speed == 0) return $urandom_range(0, 1023);
    target = (64'(cur_dur) * $urandom_range(0, 40)) / 32;
    target = (target << FRAC_SHIFT) / cur_speed;
    return (target > 64'hFFFF_FFFF) ? '1 : target[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] time_amount();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, cur_dur);
    return $urandom();
  endfunction

  task automatic send_side_command();
    cmd_t cmd;
    case ($urandom_range(0, 6))
      0: cmd = CMD_PAUSE;
      1: cmd = CMD_RESUME;
      2: cmd = CMD_STOP;
      3: cmd = CMD_SET_TIME;
      4: cmd = CMD_SEEK;
      5: cmd = CMD_REWIND;
      default: cmd = CMD_PLAY;
    endcase
    send_request(cmd, time_amount(), $urandom_range(0, 3) == 0, $urandom_range(0, 1));
  endtask

  // mostly start-then-tick runs, some raw noise
  task automatic run_random(input int count);
    int target;
    int n;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0, 1: send_request(CMD_PLAY, $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
          2, 3: send_request(CMD_REWIND, $urandom(), $urandom_range(0, 1),
                             $urandom_range(0, 1));
          4:    send_request(CMD_SEEK, time_amount(), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 1));
          default: send_request(CMD_RESUME, $urandom(), $urandom_range(0, 1),
                                $urandom_range(0, 1));
        endcase
        n = $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 4) == 0) send_side_command();
          send_request(CMD_TICK, tick_amount(), $urandom_range(0, 1), $urandom_range(0, 1));
        end
      end else begin
        send_request(cmd_t'($urandom_range(0, 7)), $urandom(), $urandom_range(0, 1),
                     $urandom_range(0, 1));
      end
      if ($urandom_range(0, 39) == 0) wait_idle();
      if ($urandom_range(0, 29) == 0) tx_calm = ~tx_calm;
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_TICK;
    in_ch.amount         = '0;
    in_ch.seek_paused    = 1'b0;
    in_ch.seek_rewinding = 1'b0;
    sent_count           = 0;
    tx_calm              = 1'b0;
    cur_dur              = DURATION_RST;
    cur_speed            = SPEED_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: one second, unit speed, no looping
    send_request(CMD_TICK, 32'd100, 1'b0, 1'b0);        // stopped: ignored
    send_request(CMD_PLAY, 32'd0, 1'b1, 1'b1);
    send_request(CMD_TICK, 32'h0000_8000, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0);  // clamped, runs off the end
    send_request(CMD_REWIND, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'h0000_0100, 1'b0, 1'b0);  // runs off the start
    send_request(CMD_REWIND, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'h0000_4000, 1'b0, 1'b0);
    send_request(CMD_PAUSE, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'd5, 1'b0, 1'b0);
    send_request(CMD_RESUME, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'd5, 1'b0, 1'b0);
    send_request(CMD_SEEK, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(CMD_SEEK, 32'h0001_2345, 1'b0, 1'b0);
    send_request(CMD_SET_TIME, 32'hFFFF_FFFF, 1'b0, 1'b0); // beyond duration
    send_request(CMD_TICK, 32'd1, 1'b0, 1'b0);
    send_request(CMD_PLAY, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'h0001_0000, 1'b0, 1'b0);  // lands exactly on the end
    send_request(CMD_SET_TIME, 32'h0002_0000, 1'b0, 1'b0);
    send_request(CMD_REWIND, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'd1, 1'b0, 1'b0);
    send_request(CMD_STOP, 32'd0, 1'b0, 1'b0);          // keeps rewinding
    set_config(32'h0001_0000, 16'hFFFF, 1'b1);
    send_request(CMD_PLAY, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_request(CMD_REWIND, 32'd0, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'd1, 1'b0, 1'b0);
    send_request(CMD_SET_TIME, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_request(CMD_TICK, 32'd0, 1'b0, 1'b0);

    set_config(32'h0001_0000, 16'd256, 1'b1);
    run_random(30);
    wait_idle();
    run_random(30);
    set_config(32'd1, 16'd0, 1'b0);
    run_random(60);
    set_config(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    run_random(60);
    set_config(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    run_random(60);
    set_config($urandom_range(100, 5000), $urandom_range(1, 1024), 1'b1);
    run_random(60);
    tx_calm = ($urandom_range(0, 3) == 0);
    set_config($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(0, 16'hFFFF), 1'b0);
    run_random(60);
    set_config(32'd1, 16'hFFFF, 1'b1);
    run_random(60);
    set_config(32'h0001_0000 * $urandom_range(1, 10), 16'd256, $urandom_range(0, 1));
    run_random(60);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: animation_playhead_timer.f
hdl/aph_pkg.sv
hdl/aph_if.sv
hdl/aph_alu.sv
hdl/aph_cfg.sv
hdl/aph_core.sv
hdl/animation_playhead_timer.sv
hdl/aph_chk.sv
tb/sv/playhead_checker.sv
tb/sv/tb_top.sv
